FILE: sv/ugam_pkg.sv
// ugam_pkg: shared widths, constants and handshake structs of the glyph atlas mapper
// no dependencies; imported by ugam_decoder, ugam_divider and utf8_glyph_atlas_mapper
`timescale 1ns / 1ps

package ugam_pkg;

  // field widths
  localparam int CP_W     = 21;
  localparam int BYTE_W   = 8;
  localparam int GEOM_W   = 9;
  localparam int CELL_W   = 8;
  localparam int POS_W    = 8;
  localparam int VTX_W    = 10;
  localparam int SLOT_W   = 14;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // default batch capacity in glyphs
  localparam int BATCH_GLYPHS_DEF = 256;

  // register reset values and the largest geometry that is honored
  localparam logic [GEOM_W-1:0] GEOM_RESET = 9'd16;
  localparam logic [GEOM_W-1:0] GEOM_MAX   = 9'd256;

  // register indexes (address bit 2)
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // request kinds on the input tuser bit
  localparam logic OP_TEXT        = 1'b0;
  localparam logic OP_CLEAR_BATCH = 1'b1;

  // utf-8 lead byte classes
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_BITS = 8'h07;
  localparam logic [7:0] CONT_BITS  = 8'h3F;
  localparam logic [7:0] ASCII_LIMIT = 8'h80;

  // atlas mapping ranges
  localparam logic [CP_W-1:0] ASCII_FIRST      = 21'd32;
  localparam logic [CP_W-1:0] ASCII_LAST       = 21'd126;
  localparam logic [CP_W-1:0] HANGUL_FIRST     = 21'h00AC00;
  localparam logic [CP_W-1:0] HANGUL_LAST      = 21'h00D7A3;
  localparam logic [CP_W-1:0] HANGUL_SLOT_BASE = 21'd95;

  // decoder result toward the sequencer
  typedef struct packed {
    logic            have;
    logic [CP_W-1:0] cp;
  } dec_rsp_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [SLOT_W-1:0] dividend;
    logic [GEOM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] quotient;
    logic [GEOM_W-1:0] remainder;
  } div_rsp_t;

endpackage

FILE: sv/ugam_decoder.sv
// ugam_decoder: utf-8 byte decoder holding the partial code point and pending count
// depends on ugam_pkg
`timescale 1ns / 1ps

module ugam_decoder import ugam_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,        // a text byte request is taken
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              string_end,
  output dec_rsp_t          rsp
);

  logic [CP_W-1:0] partial_r, partial_nxt;
  logic [1:0]      pending_r, pending_nxt;
  logic [CP_W-1:0] shifted;

  assign shifted = {partial_r[CP_W-7:0], text_byte[5:0] & CONT_BITS[5:0]};

  // decode one byte against the current sequence state
  always_comb begin
    partial_nxt = partial_r;
    pending_nxt = pending_r;
    rsp.have    = 1'b0;
    rsp.cp      = '0;
    if (pending_r == 2'd0) begin
      if (text_byte < ASCII_LIMIT) begin
        rsp.have = 1'b1;
        rsp.cp   = {{(CP_W-BYTE_W){1'b0}}, text_byte};
      end else if ((text_byte & LEAD2_MASK) == LEAD2_CODE) begin
        partial_nxt = {{(CP_W-BYTE_W){1'b0}}, text_byte & LEAD2_BITS};
        pending_nxt = 2'd1;
      end else if ((text_byte & LEAD3_MASK) == LEAD3_CODE) begin
        partial_nxt = {{(CP_W-BYTE_W){1'b0}}, text_byte & LEAD3_BITS};
        pending_nxt = 2'd2;
      end else if ((text_byte & LEAD4_MASK) == LEAD4_CODE) begin
        partial_nxt = {{(CP_W-BYTE_W){1'b0}}, text_byte & LEAD4_BITS};
        pending_nxt = 2'd3;
      end
    end else begin
      partial_nxt = shifted;
      pending_nxt = pending_r - 2'd1;
      if (pending_r == 2'd1) begin
        rsp.have = 1'b1;
        rsp.cp   = shifted;
      end
    end
    // a string close drops any cut-off sequence
    if (string_end) begin
      partial_nxt = '0;
      pending_nxt = 2'd0;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      pending_r <= 2'd0;
    end else if (step) begin
      partial_r <= partial_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

FILE: sv/ugam_divider.sv
// ugam_divider: restoring divider, one quotient bit per cycle, slot by column count
// depends on ugam_pkg
`timescale 1ns / 1ps

module ugam_divider import ugam_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(SLOT_W);

  logic [SLOT_W-1:0] dvd_r, dvd_nxt;      // dividend shifts out, quotient shifts in
  logic [GEOM_W-1:0] dvs_r;
  logic [GEOM_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [GEOM_W:0]   trial;
  logic              fits;

  // one compare and subtract per step
  assign trial = {rem_r, dvd_r[SLOT_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt = fits ? GEOM_W'(trial - {1'b0, dvs_r}) : trial[GEOM_W-1:0];
    dvd_nxt = {dvd_r[SLOT_W-2:0], fits};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SLOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: sv/utf8_glyph_atlas_mapper.sv
// utf8_glyph_atlas_mapper: top level, stream ports, apb registers and request sequencer
// depends on ugam_pkg, ugam_decoder, ugam_divider
`timescale 1ns / 1ps

// UTF-8 text bytes come in one request at a time and are decoded into code points;
// printable ASCII and Hangul syllables are placed in a glyph atlas whose geometry is
// set through the register port (columns at 0x0, rows at 0x4, both reset to 16).
// A byte that neither ends a glyph nor closes a string is taken and the input stays
// ready. A glyph with an atlas slot and a nonzero column count goes through the
// shared restoring divider, even when its row turns out to lie beyond the atlas: the
// divider works out the 14-bit slot number one quotient bit at a time, its registered
// done flag moves the sequencer to the emit state, and the output register then loads
// the result. The input is ready again in the cycle in which the result is offered.
// Any other glyph, and a string close without a glyph, goes straight from the byte to
// the emit state. The input is not ready while a glyph is in flight, and a new result
// also waits while the previous one has not been taken; a finished result waits in
// the output register while the next byte is taken. Every string close yields a
// result with tlast set, even when no glyph ends on that byte.
module utf8_glyph_atlas_mapper import ugam_pkg::*; #(
  parameter int BATCH_GLYPHS = BATCH_GLYPHS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] text_byte
  input  logic                  in_tuser,    // [0] opcode
  input  logic                  in_tlast,    // string_end
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [20:0] code_point, [21] in_atlas, [29:22] cell_column, [37:30] cell_row,
  // [45:38] glyph_position, [55:46] first_vertex, [56] batch_overflow, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,   // [0] glyph_valid
  output logic                  out_tlast,   // last_of_string
  // register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int BCNT_W = $clog2(BATCH_GLYPHS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // registers
  logic [GEOM_W-1:0] cols_r, rows_r;
  logic [GEOM_W-1:0] cols_eff, rows_eff;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cols_eff   = (cols_r > GEOM_MAX) ? GEOM_MAX : cols_r;
  assign rows_eff   = (rows_r > GEOM_MAX) ? GEOM_MAX : rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= GEOM_RESET;
      rows_r <= GEOM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_COLUMNS: cols_r <= cfg_pwdata[GEOM_W-1:0];
        REG_ROWS:    rows_r <= cfg_pwdata[GEOM_W-1:0];
        default:     ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_paddr[2])
      REG_COLUMNS: cfg_prdata = {{(CFG_DATA_W-GEOM_W){1'b0}}, cols_r};
      REG_ROWS:    cfg_prdata = {{(CFG_DATA_W-GEOM_W){1'b0}}, rows_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // request acceptance
  logic in_fire, text_fire, clear_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign text_fire  = in_fire & (in_tuser == OP_TEXT);
  assign clear_fire = in_fire & (in_tuser == OP_CLEAR_BATCH);

  // utf-8 decoder
  dec_rsp_t dec;

  ugam_decoder u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (text_fire),
    .text_byte  (in_tdata),
    .string_end (in_tlast),
    .rsp        (dec)
  );

  // slot mapping of the decoded code point
  logic              is_ascii, is_hangul, mapped;
  logic [SLOT_W-1:0] slot;

  assign is_ascii  = (dec.cp >= ASCII_FIRST) && (dec.cp <= ASCII_LAST);
  assign is_hangul = (dec.cp >= HANGUL_FIRST) && (dec.cp <= HANGUL_LAST);
  assign mapped    = is_ascii | is_hangul;

  always_comb begin
    if (is_hangul) begin
      slot = SLOT_W'(dec.cp - HANGUL_FIRST + HANGUL_SLOT_BASE);
    end else begin
      slot = SLOT_W'(dec.cp - ASCII_FIRST);
    end
  end

  // string and batch counters, first vertex
  logic [POS_W-1:0]       str_cnt_r;
  logic [BCNT_W-1:0]      batch_cnt_r;
  logic                   batch_full;
  logic [BCNT_W+VTX_W+1:0] vtx_wide;

  assign batch_full = batch_cnt_r >= BCNT_W'(BATCH_GLYPHS);
  assign vtx_wide   = {{VTX_W{1'b0}}, batch_cnt_r, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      str_cnt_r   <= '0;
      batch_cnt_r <= '0;
    end else begin
      if (clear_fire) begin
        batch_cnt_r <= '0;
      end else if (text_fire && dec.have && !batch_full) begin
        batch_cnt_r <= batch_cnt_r + 1'b1;
      end
      if (text_fire) begin
        if (in_tlast) begin
          str_cnt_r <= '0;
        end else if (dec.have) begin
          str_cnt_r <= str_cnt_r + 1'b1;
        end
      end
    end
  end

  // result held while the divider runs
  logic              p_glyph_r;
  logic [CP_W-1:0]   p_cp_r;
  logic [POS_W-1:0]  p_pos_r;
  logic [VTX_W-1:0]  p_vtx_r;
  logic              p_ovf_r;
  logic              p_last_r;
  logic              p_div_r;      // slot was divided, quotient and remainder are live

  logic start_div;

  assign start_div = text_fire && dec.have && mapped && (cols_eff != '0);

  always_ff @(posedge clk) begin
    if (text_fire) begin
      p_glyph_r <= dec.have;
      p_cp_r    <= dec.have ? dec.cp : '0;
      p_pos_r   <= dec.have ? str_cnt_r : '0;
      p_vtx_r   <= (dec.have && !batch_full) ? vtx_wide[VTX_W-1:0] : '0;
      p_ovf_r   <= dec.have && batch_full;
      p_last_r  <= in_tlast;
      p_div_r   <= start_div;
    end
  end

  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign div_req.start    = start_div;
  assign div_req.dividend = slot;
  assign div_req.divisor  = cols_eff;

  ugam_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer
  logic out_free;

  assign out_free = !out_tvalid || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (text_fire && (dec.have || in_tlast)) begin
          state_nxt = start_div ? S_DIV : S_EMIT;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // atlas cell from quotient and remainder
  logic              in_atlas;
  logic [CELL_W-1:0] cell_col, cell_row;

  assign in_atlas = p_div_r && (div_rsp.quotient < {{(SLOT_W-GEOM_W){1'b0}}, rows_eff});
  assign cell_col = in_atlas ? div_rsp.remainder[CELL_W-1:0] : '0;
  assign cell_row = in_atlas ? div_rsp.quotient[CELL_W-1:0] : '0;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;
  logic                  out_last_r;
  logic                  emit;

  assign emit = (state_r == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {7'd0, p_ovf_r, p_vtx_r, p_pos_r, cell_row, cell_col, in_atlas, p_cp_r};
      out_user_r <= p_glyph_r;
      out_last_r <= p_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
